/* hdl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/lih_pkg.sv */
// ---------------------------------------------------------------------------
// lih_pkg
// shared constants and codes of the list interning hash table
// ---------------------------------------------------------------------------
package lih_pkg;
  localparam int unsigned MaxLists    = 1024;
  localparam int unsigned StoreWords  = 4096;
  localparam int unsigned HashBuckets = 256;

  localparam logic [1:0] ReqPush   = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;
  localparam logic [1:0] ReqClear  = 2'd3;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StPresent  = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StLocked   = 3'd4;

  localparam int unsigned IndexW  = 10;
  localparam int unsigned StatusW = 3;
endpackage

/* hdl/lih_req_if.sv */
// ---------------------------------------------------------------------------
// lih_req_if
// request channel: valid, ready, request type and element
// ---------------------------------------------------------------------------
interface lih_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] element;
  modport source (output valid, req_type, element, input ready);
  modport sink   (input valid, req_type, element, output ready);
endinterface

/* hdl/lih_rsp_if.sv */
// ---------------------------------------------------------------------------
// lih_rsp_if
// response channel: valid, ready, list index and status
// ---------------------------------------------------------------------------
interface lih_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lih_pkg::IndexW-1:0]     list_index;
  logic [lih_pkg::StatusW-1:0]    status;
  modport source (output valid, list_index, status, input ready);
  modport sink   (input valid, list_index, status, output ready);
endinterface

/* hdl/lih_ram.sv */
// ---------------------------------------------------------------------------
// lih_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module lih_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/list_interning_hash_table.sv */
// ---------------------------------------------------------------------------
// list_interning_hash_table
// hash-consing table that interns lists of signed 32-bit integers
// ---------------------------------------------------------------------------
// Usage: requests arrive on req (valid/ready); push (0) appends an element,
// insert (1) and lookup (2) finish the pending list and give one transaction
// on rsp with list index and status, clear (3) empties the table.
// insert_locked is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, and the block itself does not enforce this. A push is
// taken in the idle state and the next request can follow at once. A finish
// reads the bucket head, then walks the chain through one shared compare
// unit, by hash, length, then element words; a match answers present, and
// the chain end or an entry that sorts higher ends the walk (insert links
// the new entry there). A locked or overflowed list goes straight to the
// response. Every table memory has one read port.
// After reset, and after each clear, a sweep over all buckets zeroes
// the bucket heads; no request is taken meanwhile (config writes are).
// The response sits in an output register; while the receiver stalls the
// block holds it and accepts no new request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module list_interning_hash_table #(
  parameter int unsigned MaxLists    = lih_pkg::MaxLists,
  parameter int unsigned StoreWords  = lih_pkg::StoreWords,
  parameter int unsigned HashBuckets = lih_pkg::HashBuckets
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  lih_req_if.sink   req,
  lih_rsp_if.source rsp
);
  localparam int unsigned LW = $clog2(MaxLists);
  localparam int unsigned EW = $clog2(MaxLists + 1);
  localparam int unsigned SW = $clog2(StoreWords);
  localparam int unsigned TW = $clog2(StoreWords + 1);
  localparam int unsigned BW = (HashBuckets > 1) ? $clog2(HashBuckets) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_LEN, S_CMP, S_CMPW,
    S_LINK, S_RSP
  } state_e;

  state_e              state_q;
  logic                locked_q;
  logic [EW-1:0]       nfe_q;
  logic [TW-1:0]       top_q;
  logic [31:0]         hash_q;
  logic                ovf_q;
  logic [BW-1:0]       clr_q;
  logic [TW-1:0]       pstart_q;
  logic [LW-1:0]       cur_q, prev_q;
  logic [TW-1:0]       xstart_q;
  logic [TW-1:0]       ci_q;
  logic                lookup_q;
  logic [lih_pkg::IndexW-1:0]  idx_q;
  logic [lih_pkg::StatusW-1:0] st_q;
  logic                rvalid_q;
  logic [31:0]         wa_q;
  // second write into next array when linking after a predecessor
  logic                link2_q;

  // memory ports
  logic               hd_we;  logic [BW-1:0] hd_wa, hd_ra; logic [LW-1:0] hd_wd, hd_rd;
  logic               nx_we;  logic [LW-1:0] nx_wa, nx_ra, nx_wd, nx_rd;
  logic               hh_we;  logic [LW-1:0] hh_wa, hh_ra; logic [31:0] hh_wd, hh_rd;
  logic               es_we;  logic [EW-1:0] es_wa, es_ra; logic [TW-1:0] es_wd, es_rd;
  logic               el_we;  logic [SW-1:0] el_wa, el_ra; logic [31:0] el_wd, el_rd;

  lih_ram #(.Width(LW), .Depth(HashBuckets)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  lih_ram #(.Width(LW), .Depth(MaxLists)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd));
  lih_ram #(.Width(32), .Depth(MaxLists)) u_hash (
    .clk_i, .we_i(hh_we), .waddr_i(hh_wa), .wdata_i(hh_wd), .raddr_i(hh_ra), .rdata_o(hh_rd));
  lih_ram #(.Width(TW), .Depth(MaxLists + 1)) u_start (
    .clk_i, .we_i(es_we), .waddr_i(es_wa), .wdata_i(es_wd), .raddr_i(es_ra), .rdata_o(es_rd));
  lih_ram #(.Width(32), .Depth(StoreWords)) u_elem (
    .clk_i, .we_i(el_we), .waddr_i(el_wa), .wdata_i(el_wd), .raddr_i(el_ra), .rdata_o(el_rd));

  logic          req_fire;
  logic [BW-1:0] bucket;
  logic [TW-1:0] plen, zlen;
  logic [31:0]   u_a, u_b;
  logic          cmp_gt, cmp_eq;

  assign req.ready  = (state_q == S_IDLE) && !rvalid_q;
  assign req_fire   = req.valid && req.ready;
  assign rsp.valid  = rvalid_q;
  assign rsp.list_index = idx_q;
  assign rsp.status = st_q;
  assign bucket     = BW'(hash_q % HashBuckets);
  assign plen       = top_q - pstart_q;
  // shared compare unit: signed compare via biased unsigned compare
  assign u_a    = wa_q ^ 32'h8000_0000;
  assign u_b    = el_rd ^ 32'h8000_0000;
  assign cmp_gt = u_a > u_b;
  assign cmp_eq = u_a == u_b;
  assign zlen   = es_rd - xstart_q;

  // memory addressing
  always_comb begin
    hd_we = 1'b0; hd_wa = clr_q; hd_wd = '0; hd_ra = bucket;
    nx_we = 1'b0; nx_wa = LW'(nfe_q); nx_wd = cur_q; nx_ra = cur_q;
    hh_we = 1'b0; hh_wa = LW'(nfe_q); hh_wd = hash_q; hh_ra = cur_q;
    es_we = 1'b0; es_wa = nfe_q + EW'(1); es_wd = top_q; es_ra = EW'(cur_q);
    el_we = 1'b0; el_wa = top_q[SW-1:0]; el_wd = req.element; el_ra = ci_q[SW-1:0];
    unique case (state_q)
      S_CLR: begin
        hd_we = 1'b1;
        es_we = (clr_q == '0);
        es_wa = EW'(1);
        es_wd = TW'(1);
      end
      S_IDLE: begin
        el_we = req_fire && (req.req_type == lih_pkg::ReqPush) &&
                (top_q < TW'(StoreWords));
      end
      S_ENTW: es_ra = EW'(cur_q) + EW'(1);
      // first stored word of the entry
      S_LEN: el_ra = xstart_q[SW-1:0];
      // next stored word
      S_CMPW: el_ra = SW'(ci_q + TW'(1) - pstart_q + xstart_q);
      S_LINK: begin
        if (!lookup_q && (nfe_q < EW'(MaxLists))) begin
          nx_we = 1'b1;
          hh_we = 1'b1;
          es_we = 1'b1;
          if (prev_q == '0) begin
            hd_we = 1'b1;
            hd_wa = bucket;
            hd_wd = LW'(nfe_q);
          end
        end
      end
      S_RSP: begin
        if (link2_q) begin
          nx_we = 1'b1;
          nx_wa = prev_q;
          nx_wd = LW'(nfe_q - EW'(1));
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      locked_q <= 1'b0;
      nfe_q    <= EW'(1);
      top_q    <= TW'(1);
      pstart_q <= TW'(1);
      hash_q   <= '0;
      ovf_q    <= 1'b0;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
      link2_q  <= 1'b0;
    end else begin
      if (cfg_we_i) locked_q <= cfg_wdata_i;
      if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + BW'(1);
          if (clr_q == BW'(HashBuckets - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_fire) begin
            unique case (req.req_type)
              lih_pkg::ReqPush: begin
                hash_q <= hash_q + req.element;
                if (top_q < TW'(StoreWords)) top_q <= top_q + TW'(1);
                else ovf_q <= 1'b1;
              end
              lih_pkg::ReqClear: begin
                locked_q <= 1'b0;
                nfe_q    <= EW'(1);
                top_q    <= TW'(1);
                pstart_q <= TW'(1);
                hash_q   <= '0;
                ovf_q    <= 1'b0;
                clr_q    <= '0;
                state_q  <= S_CLR;
              end
              default: begin
                lookup_q <= (req.req_type == lih_pkg::ReqLookup);
                idx_q    <= '0;
                if (req.req_type == lih_pkg::ReqInsert && locked_q) begin
                  st_q <= lih_pkg::StLocked; state_q <= S_RSP;
                end else if (ovf_q) begin
                  st_q <= lih_pkg::StFull; state_q <= S_RSP;
                end else begin
                  state_q <= S_HEAD;
                end
              end
            endcase
          end
        end
        S_HEAD: begin
          prev_q  <= '0;
          state_q <= S_HEADW;
        end
        S_HEADW: begin
          cur_q   <= hd_rd;
          state_q <= S_ENT;
        end
        S_ENT: begin
          if (cur_q == '0) state_q <= S_LINK;
          else state_q <= S_ENTW;
        end
        S_ENTW: begin
          // hash and start of current entry are read; fetch end next
          xstart_q <= es_rd;
          if (hh_rd > hash_q) state_q <= S_LINK;
          else if (hh_rd < hash_q) begin
            prev_q <= cur_q; cur_q <= nx_rd; state_q <= S_ENT;
          end else state_q <= S_LEN;
        end
        S_LEN: begin
          ci_q <= pstart_q;
          if (zlen > plen) state_q <= S_LINK;
          else if (zlen < plen) begin
            prev_q <= cur_q; cur_q <= nx_rd; state_q <= S_ENT;
          end else if (zlen == '0) begin
            idx_q <= cur_q; st_q <= lih_pkg::StPresent; state_q <= S_RSP;
          end else state_q <= S_CMP;
        end
        S_CMP: begin
          // stored word is on the read port; fetch the pending one
          wa_q    <= el_rd;
          state_q <= S_CMPW;
        end
        S_CMPW: begin
          if (!cmp_eq && cmp_gt) state_q <= S_LINK;
          else if (!cmp_eq) begin
            prev_q <= cur_q; cur_q <= nx_rd; state_q <= S_ENT;
          end else if (ci_q + TW'(1) == top_q) begin
            idx_q <= cur_q; st_q <= lih_pkg::StPresent; state_q <= S_RSP;
          end else begin
            ci_q    <= ci_q + TW'(1);
            state_q <= S_CMP;
          end
        end
        S_LINK: begin
          if (lookup_q) begin
            st_q <= lih_pkg::StNotFound;
          end else if (nfe_q >= EW'(MaxLists)) begin
            st_q <= lih_pkg::StFull;
          end else begin
            st_q     <= lih_pkg::StInserted;
            idx_q    <= lih_pkg::IndexW'(nfe_q);
            link2_q  <= (prev_q != '0);
            nfe_q    <= nfe_q + EW'(1);
            pstart_q <= top_q;
          end
          state_q <= S_RSP;
        end
        S_RSP: begin
          rvalid_q <= 1'b1;
          link2_q  <= 1'b0;
          top_q    <= (st_q == lih_pkg::StInserted) ? top_q : pstart_q;
          hash_q   <= '0;
          ovf_q    <= 1'b0;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_rsp_in_clear, clk_i, rst_ni, rvalid_q && (state_q == S_CLR) && $rose(rvalid_q))
  `ASSERT_IMPL(a_rsp_hold, clk_i, rst_ni, (rvalid_q && !rsp.ready) |=> rvalid_q)
  `ASSERT_IMPL(a_no_ready_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !req.ready)
endmodule

/* verif/list_interning_hash_table_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// list_interning_hash_table_tb
// self-checking bench: a behavioural copy of the intern table predicts the
// index and status of every finishing request; directed cases, lock handling
// and random list traffic with back-pressure
// ---------------------------------------------------------------------------
module list_interning_hash_table_tb;

  typedef struct packed {
    logic [lih_pkg::IndexW-1:0]  idx;
    logic [lih_pkg::StatusW-1:0] st;
  } answer_t;

  typedef logic [31:0] word_list_t[$];

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  lih_req_if req_ch ();
  lih_rsp_if rsp_ch ();

  list_interning_hash_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // shadow copy of the table
  logic [lih_pkg::IndexW-1:0] shadow_head[lih_pkg::HashBuckets];
  logic [lih_pkg::IndexW-1:0] shadow_next[lih_pkg::MaxLists];
  logic [31:0]       shadow_hash[lih_pkg::MaxLists];
  int unsigned       shadow_start[lih_pkg::MaxLists+1];
  logic [31:0]       shadow_words[lih_pkg::StoreWords];
  int unsigned       free_entry;
  int unsigned       word_top;
  logic [31:0]       list_hash;
  bit                pending_overflow;
  bit                lock_shadow;

  answer_t     answers_due[$];
  int          failures;
  int          hold_cycles;
  int unsigned burst_left;
  bit          gaps_on;
  word_list_t  seen_lists[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void shadow_clear();
    foreach (shadow_head[i]) shadow_head[i] = '0;
    free_entry       = 1;
    shadow_start[1]  = 1;
    word_top         = 1;
    list_hash        = '0;
    pending_overflow = 1'b0;
  endfunction

  // predict the effect of one accepted transaction
  function automatic void shadow_take(logic [1:0] rt, logic [31:0] el);
    int unsigned bkt, prev, x, steps, len, z, a, b, n;
    int          order;
    answer_t     ans;
    bit          found;
    ans   = '0;
    found = 1'b0;
    if (rt == lih_pkg::ReqPush) begin
      list_hash = list_hash + el;
      if (word_top < lih_pkg::StoreWords) begin
        shadow_words[word_top] = el;
        word_top++;
      end else begin
        pending_overflow = 1'b1;
      end
      return;
    end
    if (rt == lih_pkg::ReqClear) begin
      shadow_clear();
      lock_shadow = 1'b0;
      return;
    end
    if (rt == lih_pkg::ReqInsert && lock_shadow) begin
      ans.st = lih_pkg::StLocked;
    end else if (pending_overflow) begin
      ans.st = lih_pkg::StFull;
    end else begin
      bkt   = list_hash % lih_pkg::HashBuckets;
      len   = word_top - shadow_start[free_entry];
      prev  = 0;
      x     = shadow_head[bkt];
      steps = 0;
      // walk the chain ordered by hash, length, then contents
      while (x != 0 && x < lih_pkg::MaxLists && steps < lih_pkg::MaxLists && !found) begin
        if (shadow_hash[x] > list_hash) break;
        if (shadow_hash[x] == list_hash) begin
          z = shadow_start[x+1] - shadow_start[x];
          if (z > len) break;
          if (z == len) begin
            a     = shadow_start[x];
            b     = shadow_start[free_entry];
            order = 0;
            for (int i = 0; i < len && order == 0; i++) begin
              if ($signed(shadow_words[a+i]) > $signed(shadow_words[b+i])) order = 1;
              else if ($signed(shadow_words[a+i]) < $signed(shadow_words[b+i])) order = -1;
            end
            if (order == 0) found = 1'b1;
            else if (order > 0) break;
          end
        end
        if (!found) begin
          prev = x;
          x    = shadow_next[x];
          steps++;
        end
      end
      if (found) begin
        ans.idx = x;
        ans.st  = lih_pkg::StPresent;
      end else if (rt == lih_pkg::ReqLookup) begin
        ans.st = lih_pkg::StNotFound;
      end else if (free_entry >= lih_pkg::MaxLists) begin
        ans.st = lih_pkg::StFull;
      end else begin
        if (x >= lih_pkg::MaxLists) x = 0;
        n              = free_entry;
        shadow_next[n] = x;
        shadow_hash[n] = list_hash;
        if (prev == 0) shadow_head[bkt] = n;
        else shadow_next[prev] = n;
        free_entry         = n + 1;
        shadow_start[n+1]  = word_top;
        ans.idx            = n;
        ans.st             = lih_pkg::StInserted;
      end
    end
    word_top         = shadow_start[free_entry];
    list_hash        = '0;
    pending_overflow = 1'b0;
    answers_due.push_back(ans);
  endfunction

  // response checker and receiver stall pattern
  int unsigned stall_phase;
  int unsigned stall_pct;
  always @(posedge clk_i) begin
    answer_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected transaction: list_index %0d status %0d",
               rsp_ch.list_index, rsp_ch.status);
        failures++;
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.list_index !== want.idx) begin
          $error("list_index mismatch: expected %0d actual %0d", want.idx, rsp_ch.list_index);
          failures++;
        end
        if (rsp_ch.status !== want.st) begin
          $error("status mismatch: expected %0d actual %0d", want.st, rsp_ch.status);
          failures++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      stall_phase--;
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // send one transaction, with bursts and gaps on the request side
  task automatic send_item(logic [1:0] rt, logic [31:0] el);
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
      gaps_on    = ($urandom_range(0, 9) != 0);
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.element  <= el;
    do @(posedge clk_i); while (!req_ch.ready);
    shadow_take(rt, el);
  endtask

  task automatic send_list(word_list_t words, logic [1:0] finish);
    foreach (words[i]) send_item(lih_pkg::ReqPush, words[i]);
    send_item(finish, $urandom);
  endtask

  // stop offering and wait until every answer has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lock(bit value);
    drain();
    repeat (300) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lock_shadow = value;
  endtask

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return $urandom_range(0, 3);
      5: return $urandom_range(0, 3) * 256;
      default: return $urandom;
    endcase
  endfunction

  // extremes, empty list, every request type, lock handling
  task automatic test_directed();
    word_list_t w;
    send_list(w, lih_pkg::ReqLookup);
    send_list(w, lih_pkg::ReqInsert);
    send_list(w, lih_pkg::ReqInsert);
    w = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    send_list(w, lih_pkg::ReqLookup);
    send_list(w, lih_pkg::ReqInsert);
    send_list(w, lih_pkg::ReqLookup);
    w = '{32'd1, 32'd2};
    send_list(w, lih_pkg::ReqInsert);
    w = '{32'd2, 32'd1};
    send_list(w, lih_pkg::ReqInsert);
    w = '{32'd0, 32'd3};
    send_list(w, lih_pkg::ReqInsert);
    write_lock(1'b1);
    w = '{32'd5};
    send_list(w, lih_pkg::ReqInsert);
    w = '{32'd2, 32'd1};
    send_list(w, lih_pkg::ReqLookup);
    send_item(lih_pkg::ReqClear, 32'h0);
    w = '{32'd2, 32'd1};
    send_list(w, lih_pkg::ReqLookup);
    send_list(w, lih_pkg::ReqInsert);
  endtask

  // receiver pauses fully while lists keep being offered, then drains
  task automatic test_backpressure();
    word_list_t w;
    send_item(lih_pkg::ReqClear, $urandom);
    hold_cycles = 600;
    for (int n = 0; n < 30; n++) begin
      w = '{$urandom_range(0, 3), $urandom_range(0, 3)};
      send_list(w, ($urandom_range(0, 2) == 0) ? lih_pkg::ReqLookup : lih_pkg::ReqInsert);
    end
    drain();
  endtask

  // random well-formed lists with replays, plus noise
  task automatic test_random();
    word_list_t w;
    for (int phase = 0; phase < 6; phase++) begin
      write_lock(phase % 3 == 1);
      for (int k = 0; k < 200; ) begin
        if ($urandom_range(0, 99) < 88) begin
          if (seen_lists.size() > 0 && $urandom_range(0, 1) == 1) begin
            w = seen_lists[$urandom_range(0, seen_lists.size() - 1)];
          end else begin
            w = {};
            repeat ($urandom_range(0, 6)) w.push_back(pick_element());
            if (seen_lists.size() < 64) seen_lists.push_back(w);
          end
          send_list(w, ($urandom_range(0, 4) < 3) ? lih_pkg::ReqInsert : lih_pkg::ReqLookup);
          k += w.size() + 1;
        end else if ($urandom_range(0, 19) == 0) begin
          send_item(lih_pkg::ReqClear, $urandom);
          k++;
        end else begin
          send_item(2'($urandom_range(0, 2)), $urandom);
          k++;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = lih_pkg::ReqPush;
    req_ch.element  = '0;
    rsp_ch.ready    = 1'b0;
    failures        = 0;
    hold_cycles     = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    stall_phase     = 0;
    stall_pct       = 0;
    lock_shadow     = 1'b0;
    shadow_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random();

    drain();
    repeat (300) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
